// ===== src/balu_pkg.sv =====
// ----------------------------------------------------------------------------
// balu_pkg - byte ALU shared definitions
// Opcode codes, condition code layout and small helpers used by the ALU units.
// ----------------------------------------------------------------------------
package balu_pkg;

	typedef enum logic [4:0] {
		OP_ADD  = 5'd0,
		OP_SUB  = 5'd1,
		OP_NEG  = 5'd2,
		OP_ADDX = 5'd3,
		OP_SUBX = 5'd4,
		OP_NEGX = 5'd5,
		OP_MULS = 5'd6,
		OP_MULU = 5'd7,
		OP_BTST = 5'd8,
		OP_BSET = 5'd9,
		OP_BCLR = 5'd10,
		OP_BCHG = 5'd11,
		OP_LSR  = 5'd12,
		OP_LSL  = 5'd13,
		OP_ASR  = 5'd14,
		OP_ASL  = 5'd15,
		OP_ROR  = 5'd16,
		OP_ROL  = 5'd17,
		OP_ROXR = 5'd18,
		OP_ROXL = 5'd19
	} op_t;

	// bit4 X, bit3 N, bit2 Z, bit1 V, bit0 C
	typedef struct packed {
		logic x;
		logic n;
		logic z;
		logic v;
		logic c;
	} ccr_t;

	localparam logic [5:0] SHIFT_SAT = 6'd8;

	// cnt mod 9 for a six-bit count: reciprocal 57/512 is exact over 0..63
	function automatic logic [3:0] mod9(input logic [5:0] cnt);
		logic [11:0] prod;
		logic [2:0]  quot;
		logic [5:0]  back;
		prod = 12'(cnt) * 12'd57;
		quot = prod[11:9];
		back = 6'(quot) * 6'd9;
		return 4'(cnt - back);
	endfunction

endpackage

// ===== src/balu_arith.sv =====
// ----------------------------------------------------------------------------
// balu_arith - add/sub/neg, nibble multiply and bit operations
// Combinational; covers opcodes ADD to BCHG, other codes pass dst and ccr_in.
// ----------------------------------------------------------------------------
module balu_arith (
	input  logic [4:0]          opcode,
	input  logic [7:0]          src,
	input  logic [7:0]          dst,
	input  balu_pkg::ccr_t      ccr_in,
	output logic [7:0]          result,
	output balu_pkg::ccr_t      ccr_out
);

	logic       xin;
	logic [7:0] sum;
	logic [7:0] diff;
	logic [7:0] negv;
	logic [7:0] sa;
	logic [7:0] da;
	logic [7:0] mul_s;
	logic [7:0] mul_u;
	logic [7:0] bitm;
	logic       sm, dm;

	always_comb begin
		xin = (opcode == balu_pkg::OP_ADDX || opcode == balu_pkg::OP_SUBX ||
		       opcode == balu_pkg::OP_NEGX) ? ccr_in.x : 1'b0;
		sum   = dst + src + {7'b0, xin};
		diff  = dst - src - {7'b0, xin};
		negv  = 8'd0 - dst - {7'b0, xin};
		sa    = {{4{src[7]}}, src[7:4]};
		da    = {{4{dst[7]}}, dst[7:4]};
		mul_s = sa * da;
		mul_u = {4'b0, src[7:4]} * {4'b0, dst[7:4]};
		bitm  = 8'd1 << src[2:0];
		sm    = src[7];
		dm    = dst[7];
	end

	always_comb begin
		result  = dst;
		ccr_out = ccr_in;
		unique case (opcode)
			balu_pkg::OP_ADD, balu_pkg::OP_ADDX: begin
				result    = sum;
				ccr_out.c = (sm & dm) | (~sum[7] & dm) | (sm & ~sum[7]);
				ccr_out.x = ccr_out.c;
				ccr_out.v = (sm & dm & ~sum[7]) | (~sm & ~dm & sum[7]);
				ccr_out.z = (sum == 8'd0);
				ccr_out.n = sum[7];
			end
			balu_pkg::OP_SUB, balu_pkg::OP_SUBX: begin
				result    = diff;
				ccr_out.c = (sm & ~dm) | (diff[7] & ~dm) | (sm & diff[7]);
				ccr_out.x = ccr_out.c;
				ccr_out.v = (~sm & dm & ~diff[7]) | (sm & ~dm & diff[7]);
				ccr_out.z = (diff == 8'd0);
				ccr_out.n = diff[7];
			end
			balu_pkg::OP_NEG, balu_pkg::OP_NEGX: begin
				result    = negv;
				ccr_out.c = dm | negv[7];
				ccr_out.x = ccr_out.c;
				ccr_out.v = dm & negv[7];
				ccr_out.z = (negv == 8'd0);
				ccr_out.n = negv[7];
			end
			balu_pkg::OP_MULS, balu_pkg::OP_MULU: begin
				result    = (opcode == balu_pkg::OP_MULS) ? mul_s : mul_u;
				ccr_out.c = 1'b0;
				ccr_out.v = 1'b0;
				ccr_out.z = (result == 8'd0);
				ccr_out.n = result[7];
			end
			balu_pkg::OP_BTST, balu_pkg::OP_BSET, balu_pkg::OP_BCLR,
			balu_pkg::OP_BCHG: begin
				if (opcode == balu_pkg::OP_BSET) begin
					result = dst | bitm;
				end else if (opcode == balu_pkg::OP_BCLR) begin
					result = dst & ~bitm;
				end else if (opcode == balu_pkg::OP_BCHG) begin
					result = dst ^ bitm;
				end
				// Z reflects the tested bit before it is altered
				ccr_out.z = ((dst & bitm) == 8'd0);
			end
			default: begin
				result  = dst;
				ccr_out = ccr_in;
			end
		endcase
	end

endmodule

// ===== src/balu_shift.sv =====
// ----------------------------------------------------------------------------
// balu_shift - barrel shifter for shifts and rotates
// Combinational; covers LSR to ROXL, count is src mod 64.
// ----------------------------------------------------------------------------
module balu_shift (
	input  logic [4:0]          opcode,
	input  logic [7:0]          src,
	input  logic [7:0]          dst,
	input  balu_pkg::ccr_t      ccr_in,
	output logic [7:0]          result,
	output balu_pkg::ccr_t      ccr_out
);

	logic [5:0]  cnt;
	logic        cnt_zero;
	logic        cnt_big;
	logic [3:0]  k;
	logic        is_asr;
	logic [15:0] ext;
	logic [16:0] shr;
	logic [15:0] shl;
	logic [7:0]  mask;
	logic [7:0]  top;
	logic        asl_v;
	logic [7:0]  rot_r;
	logic [15:0] rot_l;
	logic [3:0]  k9;
	logic [8:0]  w;
	logic [17:0] wr;
	logic [17:0] wl;

	always_comb begin
		cnt      = src[5:0];
		cnt_zero = (cnt == 6'd0);
		cnt_big  = (cnt > balu_pkg::SHIFT_SAT);
		k        = cnt_big ? 4'd8 : cnt[3:0];
		is_asr   = (opcode == balu_pkg::OP_ASR);
		ext      = {{8{is_asr & dst[7]}}, dst};
		// extra low bit catches the last bit shifted out
		shr      = {ext, 1'b0} >> k;
		shl      = {8'b0, dst} << k;
		mask     = 8'hFF << (3'd7 - cnt[2:0]);
		top      = dst & mask;
		// V on ASL: the bits passing through the MSB were not all alike
		if (cnt >= 6'd8) begin
			asl_v = (dst != 8'd0);
		end else begin
			asl_v = (top != 8'd0) && (top != mask);
		end
		rot_r    = 8'({dst, dst} >> cnt[2:0]);
		rot_l    = {dst, dst} << cnt[2:0];
		k9       = balu_pkg::mod9(cnt);
		w        = {ccr_in.x, dst};
		wr       = {w, w} >> k9;
		wl       = {w, w} << k9;
	end

	always_comb begin
		result  = dst;
		ccr_out = ccr_in;
		unique case (opcode)
			balu_pkg::OP_LSR, balu_pkg::OP_ASR: begin
				ccr_out.v = 1'b0;
				if (cnt_zero) begin
					ccr_out.c = 1'b0;
				end else begin
					result    = shr[8:1];
					ccr_out.c = (cnt_big && !is_asr) ? 1'b0 : shr[0];
					ccr_out.x = ccr_out.c;
				end
				ccr_out.z = (result == 8'd0);
				ccr_out.n = result[7];
			end
			balu_pkg::OP_LSL, balu_pkg::OP_ASL: begin
				ccr_out.v = 1'b0;
				if (cnt_zero) begin
					ccr_out.c = 1'b0;
				end else begin
					result    = shl[7:0];
					ccr_out.c = cnt_big ? 1'b0 : shl[8];
					ccr_out.x = ccr_out.c;
					ccr_out.v = (opcode == balu_pkg::OP_ASL) ? asl_v : 1'b0;
				end
				ccr_out.z = (result == 8'd0);
				ccr_out.n = result[7];
			end
			balu_pkg::OP_ROR, balu_pkg::OP_ROL: begin
				result    = (opcode == balu_pkg::OP_ROR) ? rot_r : rot_l[15:8];
				ccr_out.v = 1'b0;
				if (cnt_zero) begin
					ccr_out.c = 1'b0;
				end else begin
					ccr_out.c = (opcode == balu_pkg::OP_ROR) ? result[7] : result[0];
				end
				ccr_out.z = (result == 8'd0);
				ccr_out.n = result[7];
			end
			balu_pkg::OP_ROXR, balu_pkg::OP_ROXL: begin
				if (opcode == balu_pkg::OP_ROXR) begin
					result    = wr[7:0];
					ccr_out.c = wr[8];
				end else begin
					result    = wl[16:9];
					ccr_out.c = wl[17];
				end
				ccr_out.x = ccr_out.c;
				ccr_out.v = 1'b0;
				ccr_out.z = (result == 8'd0);
				ccr_out.n = result[7];
			end
			default: begin
				result  = dst;
				ccr_out = ccr_in;
			end
		endcase
	end

endmodule

// ===== src/byte_alu_with_condition_codes_core.sv =====
// ----------------------------------------------------------------------------
// byte_alu_with_condition_codes_core - byte ALU with condition codes
// Input register, single-pass ALU logic, result register.
//
//   channel  | handshake         | fields
//   ---------+-------------------+---------------------------------
//   command  | start / busy      | opcode, src, dst, ccr_in
//   result   | done (one cycle)  | result, ccr_out
//
// One beat accepted per cycle; busy is held low.
// A result appears on done after its command beat passes the input and result registers.
// Latency is set by the input and result registers around the ALU logic.
// Reset clears the pipeline valid flags only; a beat in flight at reset gives no result.
// ----------------------------------------------------------------------------
module byte_alu_with_condition_codes_core (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  logic [4:0] opcode,
	input  logic [7:0] src,
	input  logic [7:0] dst,
	input  logic [4:0] ccr_in,
	output logic       done,
	output logic [7:0] result,
	output logic [4:0] ccr_out
);

	logic           accept;
	logic           valid_s1;
	logic [4:0]     opcode_s1;
	logic [7:0]     src_s1;
	logic [7:0]     dst_s1;
	logic [4:0]     ccr_s1;
	logic           valid_s2;
	logic [7:0]     result_s2;
	logic [4:0]     ccr_s2;

	logic [7:0]     arith_res;
	balu_pkg::ccr_t arith_ccr;
	logic [7:0]     shift_res;
	balu_pkg::ccr_t shift_ccr;
	logic [7:0]     alu_res;
	logic [4:0]     alu_ccr;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			opcode_s1 <= opcode;
			src_s1    <= src;
			dst_s1    <= dst;
			ccr_s1    <= ccr_in;
		end
	end

	balu_arith u_arith (
		.opcode  (opcode_s1),
		.src     (src_s1),
		.dst     (dst_s1),
		.ccr_in  (balu_pkg::ccr_t'(ccr_s1)),
		.result  (arith_res),
		.ccr_out (arith_ccr)
	);

	balu_shift u_shift (
		.opcode  (opcode_s1),
		.src     (src_s1),
		.dst     (dst_s1),
		.ccr_in  (balu_pkg::ccr_t'(ccr_s1)),
		.result  (shift_res),
		.ccr_out (shift_ccr)
	);

	always_comb begin
		priority if (opcode_s1 <= 5'(balu_pkg::OP_BCHG)) begin
			alu_res = arith_res;
			alu_ccr = arith_ccr;
		end else if (opcode_s1 <= 5'(balu_pkg::OP_ROXL)) begin
			alu_res = shift_res;
			alu_ccr = shift_ccr;
		end else begin
			// unused codes leave operand and flags alone
			alu_res = dst_s1;
			alu_ccr = ccr_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			result_s2 <= alu_res;
			ccr_s2    <= alu_ccr;
		end
	end

	assign done    = valid_s2;
	assign result  = result_s2;
	assign ccr_out = ccr_s2;

`ifndef ASSERT_OFF
	a_accept_to_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> valid_s1)
		else $error("accepted beat did not reach stage 1");

	a_s1_to_done: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 |=> done)
		else $error("stage 1 beat produced no result");

	a_no_spurious_done: assert property (@(posedge clk) disable iff (!arst_n)
		!valid_s1 |=> !done)
		else $error("result strobe without a beat");

	a_unused_passthru: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(opcode_s1) > 5'(balu_pkg::OP_ROXL))) |->
		(result == $past(dst_s1) && ccr_out == $past(ccr_s1)))
		else $error("unused opcode altered operand or flags");

	a_bitop_only_z: assert property (@(posedge clk) disable iff (!arst_n)
		(done && ($past(opcode_s1) >= 5'(balu_pkg::OP_BTST)) &&
		 ($past(opcode_s1) <= 5'(balu_pkg::OP_BCHG))) |->
		((ccr_out & 5'b11011) == ($past(ccr_s1) & 5'b11011)))
		else $error("bit operation changed a flag other than Z");
`endif

endmodule
